// ===== rtl/core/sps_pkg.sv =====
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types and constants of the stimulation pattern sequencer.
// ----------------------------------------------------------------------------
package sps_pkg;

	localparam int unsigned HEADSTAGES  = 8;
	localparam int unsigned CIRCUITS    = 16;
	localparam int unsigned PATTERNS    = 128;
	localparam int unsigned PROB_SLOTS  = 256;
	localparam int unsigned STEPS       = 16;
	localparam int unsigned ELECTRODES  = 60;

	localparam int unsigned HS_W    = $clog2(HEADSTAGES);
	localparam int unsigned CIRC_W  = $clog2(CIRCUITS);
	localparam int unsigned ROW_W   = $clog2(PATTERNS);
	localparam int unsigned SLOT_W  = $clog2(PROB_SLOTS);
	localparam int unsigned POS_W   = $clog2(STEPS);
	localparam int unsigned EL_W    = 6;
	localparam int unsigned CELL_W  = HS_W + CIRC_W;
	localparam int unsigned PAT_AW  = CELL_W + ROW_W + POS_W;
	localparam int unsigned PROB_AW = CELL_W + SLOT_W;
	localparam int unsigned MAP_AW  = CELL_W + EL_W;
	localparam int unsigned HALF_W  = 30;

	localparam logic [5:0]  HALF_SPAN        = 6'd30;
	localparam logic [5:0]  MASK_SPAN        = 6'd60;
	localparam logic [7:0]  LIMIT_SMALL      = 8'd4;
	localparam logic [7:0]  LIMIT_LARGE      = 8'd60;
	localparam logic [3:0]  LAST_CIRC_SMALL  = 4'd14;
	localparam logic [3:0]  LAST_CIRC_LARGE  = 4'd0;
	localparam logic [31:0] LFSR_SEED        = 32'hACE1_ACE1;
	localparam logic [31:0] LFSR_TAPS        = 32'hD000_0001;

	localparam logic [1:0] ACT_STIM  = 2'd0;
	localparam logic [1:0] ACT_PAT   = 2'd1;
	localparam logic [1:0] ACT_PROB  = 2'd2;
	localparam logic [1:0] ACT_MAP   = 2'd3;

	localparam logic [1:0] REG_HS_TYPES = 2'd0;
	localparam logic [1:0] REG_RANDOM   = 2'd1;
	localparam logic [1:0] REG_MULTI    = 2'd2;

	typedef struct packed {
		logic [1:0] action;
		logic [2:0] headstage;
		logic [3:0] circuit;
		logic [3:0] position;
		logic [6:0] pattern_number;
		logic [7:0] prob_slot;
		logic [5:0] electrode_slot;
		logic [7:0] write_value;
	} item_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic tbl_write;
		logic rd_slot;
		logic rd_prob;
		logic rd_pat;
		logic chk;
		logic chk_first;
		logic apply;
		logic next_circ;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic e_ok;
		logic multi;
		logic last_circ;
		logic out_busy;
	} sts_t;

endpackage

// ===== rtl/core/sps_in_if.sv =====
// ----------------------------------------------------------------------------
// sps_in_if
// Input item channel: valid/ready handshake with the item fields.
// ----------------------------------------------------------------------------
interface sps_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [2:0] headstage;
	logic [3:0] circuit;
	logic [3:0] position;
	logic [6:0] pattern_number;
	logic [7:0] prob_slot;
	logic [5:0] electrode_slot;
	logic [7:0] write_value;

	modport source (output valid, action, headstage, circuit, position, pattern_number,
		prob_slot, electrode_slot, write_value, input ready);
	modport sink (input valid, action, headstage, circuit, position, pattern_number,
		prob_slot, electrode_slot, write_value, output ready);
endinterface

// ===== rtl/core/sps_out_if.sv =====
// ----------------------------------------------------------------------------
// sps_out_if
// Result channel: valid/ready handshake with the two electrode masks.
// ----------------------------------------------------------------------------
interface sps_out_if;
	logic        valid;
	logic        ready;
	logic [29:0] left_mask;
	logic [29:0] right_mask;

	modport source (output valid, left_mask, right_mask, input ready);
	modport sink (input valid, left_mask, right_mask, output ready);
endinterface

// ===== rtl/core/sps_dp.sv =====
// ----------------------------------------------------------------------------
// sps_dp
// Datapath: tables, slot pointers, LFSR, config registers and mask build.
// ----------------------------------------------------------------------------
module sps_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sps_pkg::cmd_t        cmd,
	output sps_pkg::sts_t        sts,
	input  sps_pkg::item_t       item,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [7:0]           cfg_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [29:0]          left_mask,
	output logic [29:0]          right_mask
);

	logic [7:0]  hs_types_q;
	logic        random_q;
	logic        multi_q;
	logic [31:0] lfsr_q;
	logic [17:0] clr_cnt_q;

	logic [2:0]  hs_q;
	logic [3:0]  pos_q;
	logic [3:0]  circ_q;
	logic [6:0]  row_q;
	logic        e_ok_q;
	logic [29:0] left_q, right_q;
	logic        out_valid_q;
	logic [29:0] out_left_q, out_right_q;

	logic [7:0]  slot_mem [0:(1 << sps_pkg::CELL_W) - 1];
	logic [6:0]  prob_mem [0:(1 << sps_pkg::PROB_AW) - 1];
	logic [7:0]  pat_mem  [0:(1 << sps_pkg::PAT_AW) - 1];
	logic [5:0]  map_mem  [0:(1 << sps_pkg::MAP_AW) - 1];
	logic [7:0]  slot_rd_q;
	logic [6:0]  prob_rd_q;
	logic [7:0]  pat_rd_q;
	logic [5:0]  map_rd_q;

	logic                         hs_small;
	logic [7:0]                   limit;
	logic [sps_pkg::CELL_W-1:0]   cell_a;
	logic [31:0]                  lfsr_nx;
	logic [7:0]                   slot_new;
	logic                         e_ok;
	logic [5:0]                   e_idx;
	logic [6:0]                   row_rd;
	logic [5:0]                   r_hi;

	// memory port controls
	logic                         slot_we, prob_we, pat_we, map_we;
	logic [sps_pkg::CELL_W-1:0]   slot_a;
	logic [sps_pkg::PROB_AW-1:0]  prob_a;
	logic [sps_pkg::PAT_AW-1:0]   pat_a;
	logic [sps_pkg::MAP_AW-1:0]   map_a;
	logic [7:0]                   slot_wd, pat_wd;
	logic [6:0]                   prob_wd;
	logic [5:0]                   map_wd;
	logic                         item_cell_ok;

	assign hs_small = hs_types_q[hs_q];
	assign limit    = hs_small ? sps_pkg::LIMIT_SMALL : sps_pkg::LIMIT_LARGE;
	assign cell_a   = {hs_q, circ_q};
	assign lfsr_nx  = (lfsr_q >> 1) ^ (lfsr_q[0] ? sps_pkg::LFSR_TAPS : 32'd0);
	assign slot_new = (pos_q != 4'd0) ? slot_rd_q :
		(random_q ? lfsr_nx[7:0] : slot_rd_q + 8'd1);
	assign e_ok     = (pat_rd_q != 8'd0) && (pat_rd_q <= limit);
	assign e_idx    = pat_rd_q[5:0] - 6'd1;
	assign row_rd   = (cmd.chk_first) ? row_q + 7'd1 : row_q;
	assign r_hi     = map_rd_q - sps_pkg::HALF_SPAN;
	assign item_cell_ok = 1'b1;

	always_comb begin
		slot_we = 1'b0; prob_we = 1'b0; pat_we = 1'b0; map_we = 1'b0;
		slot_a  = cell_a;
		prob_a  = {cell_a, slot_new};
		pat_a   = {cell_a, prob_rd_q, pos_q};
		map_a   = {cell_a, e_idx};
		slot_wd = slot_new;
		prob_wd = clr_cnt_q[6:0];
		pat_wd  = 8'd0;
		map_wd  = clr_cnt_q[5:0];
		if (cmd.clear) begin
			pat_we  = 1'b1;
			pat_a   = clr_cnt_q;
			prob_we = (clr_cnt_q[17:sps_pkg::PROB_AW] == '0);
			prob_a  = clr_cnt_q[sps_pkg::PROB_AW-1:0];
			map_we  = (clr_cnt_q[17:sps_pkg::MAP_AW] == '0);
			map_a   = clr_cnt_q[sps_pkg::MAP_AW-1:0];
			slot_we = (clr_cnt_q[17:sps_pkg::CELL_W] == '0);
			slot_a  = clr_cnt_q[sps_pkg::CELL_W-1:0];
			slot_wd = 8'd0;
		end else if (cmd.tbl_write && item_cell_ok) begin
			pat_a   = {item.headstage, item.circuit, item.pattern_number, item.position};
			pat_wd  = item.write_value;
			prob_a  = {item.headstage, item.circuit, item.prob_slot};
			prob_wd = item.write_value[6:0];
			map_a   = {item.headstage, item.circuit, item.electrode_slot};
			map_wd  = item.write_value[5:0];
			pat_we  = (item.action == sps_pkg::ACT_PAT);
			prob_we = (item.action == sps_pkg::ACT_PROB);
			map_we  = (item.action == sps_pkg::ACT_MAP) &&
				({2'b00, item.electrode_slot} < sps_pkg::LIMIT_LARGE);
		end else begin
			slot_we = cmd.rd_prob && (pos_q == 4'd0);
			if (cmd.chk)
				pat_a = {cell_a, row_rd, pos_q};
		end
	end

	always_ff @(posedge clk) begin
		if (slot_we)
			slot_mem[slot_a] <= slot_wd;
		if (cmd.rd_slot)
			slot_rd_q <= slot_mem[slot_a];
	end

	always_ff @(posedge clk) begin
		if (prob_we)
			prob_mem[prob_a] <= prob_wd;
		if (cmd.rd_prob)
			prob_rd_q <= prob_mem[prob_a];
	end

	always_ff @(posedge clk) begin
		if (pat_we)
			pat_mem[pat_a] <= pat_wd;
		if (cmd.rd_pat || (cmd.chk && cmd.chk_first))
			pat_rd_q <= pat_mem[pat_a];
	end

	always_ff @(posedge clk) begin
		if (map_we)
			map_mem[map_a] <= map_wd;
		if (cmd.chk)
			map_rd_q <= map_mem[map_a];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hs_types_q  <= '0;
			random_q    <= 1'b0;
			multi_q     <= 1'b0;
			lfsr_q      <= sps_pkg::LFSR_SEED;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					sps_pkg::REG_HS_TYPES: hs_types_q <= cfg_data;
					sps_pkg::REG_RANDOM:   random_q   <= cfg_data[0];
					sps_pkg::REG_MULTI:    multi_q    <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.clear)
				clr_cnt_q <= clr_cnt_q + 18'd1;
			if (cmd.rd_prob && (pos_q == 4'd0) && random_q)
				lfsr_q <= lfsr_nx;
			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			hs_q    <= item.headstage;
			pos_q   <= item.position;
			circ_q  <= '0;
			left_q  <= '0;
			right_q <= '0;
		end
		if (cmd.next_circ)
			circ_q <= circ_q + 4'd1;
		if (cmd.rd_pat)
			row_q <= prob_rd_q;
		if (cmd.chk)
			e_ok_q <= e_ok;
		if (cmd.apply && e_ok_q) begin
			if (map_rd_q < sps_pkg::HALF_SPAN)
				left_q <= left_q | (30'd1 << map_rd_q[4:0]);
			else if (map_rd_q < sps_pkg::MASK_SPAN)
				right_q <= right_q | (30'd1 << r_hi[4:0]);
		end
		if (cmd.finish) begin
			out_left_q  <= left_q;
			out_right_q <= right_q;
		end
	end

	assign sts.clear_last = (clr_cnt_q == '1);
	assign sts.e_ok       = e_ok_q;
	assign sts.multi      = multi_q;
	assign sts.last_circ  = circ_q == (hs_small ? sps_pkg::LAST_CIRC_SMALL
		: sps_pkg::LAST_CIRC_LARGE);
	assign sts.out_busy   = out_valid_q && !out_ready;

	assign out_valid  = out_valid_q;
	assign left_mask  = out_left_q;
	assign right_mask = out_right_q;

	a_finish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q) else $error("result not raised after finish");
	a_circ_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.next_circ |-> circ_q != sps_pkg::LAST_CIRC_SMALL + 4'd1)
		else $error("circuit index ran past the last circuit");
	a_clear_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> !(cmd.tbl_write || cmd.load)) else $error("item taken during clear");

endmodule

// ===== rtl/core/sps_ctrl.sv =====
// ----------------------------------------------------------------------------
// sps_ctrl
// Controller: clearing pass, item intake and per-circuit read sequence.
// ----------------------------------------------------------------------------
module sps_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [1:0]     in_action,
	output logic           in_ready,
	input  sps_pkg::sts_t  sts,
	output sps_pkg::cmd_t  cmd
);

	localparam logic [3:0] ST_CLEAR  = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_SLOT   = 4'd2;
	localparam logic [3:0] ST_PROB   = 4'd3;
	localparam logic [3:0] ST_PAT    = 4'd4;
	localparam logic [3:0] ST_CHK    = 4'd5;
	localparam logic [3:0] ST_APPLY  = 4'd6;
	localparam logic [3:0] ST_CHK2   = 4'd7;
	localparam logic [3:0] ST_APPLY2 = 4'd8;
	localparam logic [3:0] ST_DONE   = 4'd9;

	logic [3:0] state_q, state_nx;
	logic       fire;

	assign in_ready = (state_q == ST_IDLE);
	assign fire     = in_ready && in_valid;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_last)
					state_nx = ST_IDLE;
			end
			ST_IDLE: begin
				if (fire) begin
					if (in_action == sps_pkg::ACT_STIM) begin
						cmd.load = 1'b1;
						state_nx = ST_SLOT;
					end else begin
						cmd.tbl_write = 1'b1;
					end
				end
			end
			ST_SLOT: begin
				cmd.rd_slot = 1'b1;
				state_nx    = ST_PROB;
			end
			ST_PROB: begin
				cmd.rd_prob = 1'b1;
				state_nx    = ST_PAT;
			end
			ST_PAT: begin
				cmd.rd_pat = 1'b1;
				state_nx   = ST_CHK;
			end
			ST_CHK: begin
				cmd.chk       = 1'b1;
				cmd.chk_first = 1'b1;
				state_nx      = ST_APPLY;
			end
			ST_APPLY, ST_APPLY2: begin
				cmd.apply = 1'b1;
				if (state_q == ST_APPLY && sts.e_ok && sts.multi)
					state_nx = ST_CHK2;
				else if (sts.last_circ)
					state_nx = ST_DONE;
				else begin
					cmd.next_circ = 1'b1;
					state_nx      = ST_SLOT;
				end
			end
			ST_CHK2: begin
				cmd.chk  = 1'b1;
				state_nx = ST_APPLY2;
			end
			ST_DONE: begin
				if (!sts.out_busy) begin
					cmd.finish = 1'b1;
					state_nx   = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_nx;
	end

	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clear, cmd.load, cmd.tbl_write, cmd.rd_slot, cmd.rd_prob,
			cmd.rd_pat, cmd.chk, cmd.apply, cmd.finish}))
		else $error("more than one controller step at once");
	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> in_ready) else $error("not back to idle after finish");
	a_load_seq: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.rd_slot) else $error("stimulate did not start reading");

endmodule

// ===== rtl/core/stimulation_pattern_sequencer.sv =====
// ----------------------------------------------------------------------------
// stimulation_pattern_sequencer
// Builds left/right electrode masks from pattern, probability and map tables.
// ----------------------------------------------------------------------------
// After reset the block sweeps its tables to their start values, one pattern
// table entry a cycle, and takes no item meanwhile. A table write item is
// done as it is taken. A stimulate item visits one circuit (or 15 on a
// four-electrode headstage) through single-port table reads in series: slot,
// probability, pattern, check and apply per circuit, plus a second check and
// apply when a multi pattern follows a valid electrode, then the result.
module stimulation_pattern_sequencer (
	input  logic         clk,
	input  logic         arst_n,
	sps_in_if.sink       stim_in,
	sps_out_if.source    mask_out,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [7:0]   cfg_data
);

	sps_pkg::cmd_t  cmd;
	sps_pkg::sts_t  sts;
	sps_pkg::item_t item;

	assign item.action         = stim_in.action;
	assign item.headstage      = stim_in.headstage;
	assign item.circuit        = stim_in.circuit;
	assign item.position       = stim_in.position;
	assign item.pattern_number = stim_in.pattern_number;
	assign item.prob_slot      = stim_in.prob_slot;
	assign item.electrode_slot = stim_in.electrode_slot;
	assign item.write_value    = stim_in.write_value;

	sps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (stim_in.valid),
		.in_action (stim_in.action),
		.in_ready  (stim_in.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	sps_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.item       (item),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_valid  (mask_out.valid),
		.out_ready  (mask_out.ready),
		.left_mask  (mask_out.left_mask),
		.right_mask (mask_out.right_mask)
	);

endmodule
